// File: rtl/core/rxf_pkg.sv
// Shared definitions for the serial port register block with receive queue.
// Holds codes, status bit positions and the queue control/status structs.
// No dependencies.
package rxf_pkg;

	localparam int RX_DEPTH = 16;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_RX    = 2'd2;

	localparam logic [1:0] REG_DATA    = 2'd0;
	localparam logic [1:0] REG_STATUS  = 2'd1;
	localparam logic [1:0] REG_COMMAND = 2'd2;
	localparam logic [1:0] REG_CONTROL = 2'd3;

	localparam int ST_OVR_BIT  = 2;
	localparam int ST_RDRF_BIT = 3;
	localparam int ST_TDRE_BIT = 4;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       flush;
		logic [7:0] data;
	} rxf_ctl_t;

	typedef struct packed {
		logic       nonempty;
		logic       full;
		logic [7:0] head;
	} rxf_stat_t;

endpackage

// File: rtl/core/rxf_cell.sv
// One byte cell of the receive queue.
// Loads a new byte, takes its neighbor's byte on a shift, or holds.
// No dependencies.
module rxf_cell (
	input  logic       clk,
	input  logic       load,
	input  logic       shift,
	input  logic [7:0] load_data,
	input  logic [7:0] next_data,
	output logic [7:0] data
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

// File: rtl/core/rxf_chain.sv
// Receive queue built as a row of byte cells with the oldest byte in cell 0.
// Uses rxf_pkg for the control and status structs, and rxf_cell.
module rxf_chain #(
	parameter int DEPTH = rxf_pkg::RX_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rxf_pkg::rxf_ctl_t  ctl,
	output rxf_pkg::rxf_stat_t stat
);

	localparam int NCELL = DEPTH - 1;
	localparam int CW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	logic [CW-1:0] count_q;
	logic [7:0]    cell_data [NCELL];

	genvar i;
	generate
		for (i = 0; i < NCELL; i++) begin : g_cell
			logic [7:0] nxt;
			if (i == NCELL - 1) begin : g_last
				assign nxt = 8'd0;
			end else begin : g_mid
				assign nxt = cell_data[i+1];
			end
			rxf_cell u_cell (
				.clk       (clk),
				.load      (ctl.push && (count_q == CW'(i))),
				.shift     (ctl.pop),
				.load_data (ctl.data),
				.next_data (nxt),
				.data      (cell_data[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.flush) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_comb begin
		stat.nonempty = (count_q != '0);
		stat.full     = (count_q == CW'(NCELL));
		stat.head     = cell_data[0];
	end

endmodule

// File: rtl/core/serial_port_registers_rx_fifo_core.sv
// Serial port register face with a receive queue of DEPTH-1 bytes.
// The result beat is registered: it appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the output register frees while taken.
// Queue update and register access resolve in the same cycle.
// Reset: asynchronous, clears the queue count, overrun, command and control.
// Uses rxf_pkg and rxf_chain.
module serial_port_registers_rx_fifo_core #(
	parameter int RX_DEPTH = rxf_pkg::RX_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [1:0] reg_offset,
	input  logic [7:0] write_data,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       tx_valid,
	output logic [7:0] tx_byte
);

	rxf_pkg::rxf_ctl_t  ctl;
	rxf_pkg::rxf_stat_t stat;

	logic       out_valid_q;
	logic       ovr_q;
	logic [7:0] command_q;
	logic [7:0] control_q;
	logic [7:0] read_data_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;

	logic       accept;
	logic       is_read;
	logic       is_write;
	logic       is_rx;
	logic [7:0] status;
	logic [7:0] rd_next;

	rxf_chain #(
		.DEPTH (RX_DEPTH)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_read  = (mode == rxf_pkg::MODE_READ);
	assign is_write = (mode == rxf_pkg::MODE_WRITE);
	assign is_rx    = (mode == rxf_pkg::MODE_RX);

	always_comb begin
		status = 8'd0;
		status[rxf_pkg::ST_OVR_BIT]  = ovr_q;
		status[rxf_pkg::ST_RDRF_BIT] = stat.nonempty;
		status[rxf_pkg::ST_TDRE_BIT] = 1'b1;
	end

	always_comb begin
		ctl.push  = accept && is_rx && !stat.full;
		ctl.pop   = accept && is_read && (reg_offset == rxf_pkg::REG_DATA) && stat.nonempty;
		ctl.flush = accept && is_write && (reg_offset == rxf_pkg::REG_STATUS);
		ctl.data  = rx_byte;
	end

	always_comb begin
		rd_next = 8'd0;
		if (is_read) begin
			case (reg_offset)
				rxf_pkg::REG_DATA:    rd_next = stat.nonempty ? stat.head : 8'd0;
				rxf_pkg::REG_STATUS:  rd_next = status;
				rxf_pkg::REG_COMMAND: rd_next = command_q;
				default:              rd_next = control_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ovr_q       <= 1'b0;
			command_q   <= 8'd0;
			control_q   <= 8'd0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.flush) begin
				ovr_q     <= 1'b0;
				command_q <= 8'd0;
				control_q <= 8'd0;
			end else if (accept && is_write) begin
				case (reg_offset)
					rxf_pkg::REG_COMMAND: command_q <= write_data;
					rxf_pkg::REG_CONTROL: control_q <= write_data;
					default:              ;
				endcase
			end else if (accept && is_rx && stat.full) begin
				ovr_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= rd_next;
			tx_valid_q  <= is_write && (reg_offset == rxf_pkg::REG_DATA);
			tx_byte_q   <= (is_write && (reg_offset == rxf_pkg::REG_DATA)) ? write_data : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign tx_valid  = tx_valid_q;
	assign tx_byte   = tx_byte_q;

endmodule
